>>> hdl/sgp_pkg.sv
// shared constants and types for the slab gather planner
package sgp_pkg;

  localparam int MAX_LIST_DEF  = 64;
  localparam int PAGE_BITS_DEF = 16;
  localparam int CFG_W         = 16;
  localparam int IDX_W         = 6;
  localparam logic [CFG_W-1:0] PPS_RESET = 16'd256;

  // divider request handed from the planner's sequencer to the divider
  typedef struct packed {
    logic             start;
    logic [CFG_W-1:0] dividend;
    logic [CFG_W-1:0] divisor;
  } div_req_t;

endpackage

>>> hdl/sgp_divider.sv
// restoring divider, one quotient bit per cycle
module sgp_divider (
  input  logic                        clk,
  input  logic                        rst_n,
  input  sgp_pkg::div_req_t           req,
  output logic                        done,
  output logic [sgp_pkg::CFG_W-1:0]   quot,
  output logic [sgp_pkg::CFG_W-1:0]   rem
);
  localparam int W = sgp_pkg::CFG_W;
  localparam int CW = $clog2(W + 1);

  logic [W-1:0]  q_r, d_r;
  logic [W:0]    r_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r, done_r;
  logic [W:0]    trial;
  logic [W:0]    shifted;

  assign shifted = {r_r[W-1:0], q_r[W-1]};
  assign trial   = shifted - {1'b0, d_r};

  // iterate over quotient bits, msb first
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      // done pulses for one cycle after the final quotient bit
      done_r <= busy_r && !req.start && (cnt_r == CW'(1));
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(W);
        q_r    <= req.dividend;
        d_r    <= req.divisor;
        r_r    <= '0;
      end else if (busy_r) begin
        if (!trial[W]) begin
          r_r <= trial;
          q_r <= {q_r[W-2:0], 1'b1};
        end else begin
          r_r <= shifted;
          q_r <= {q_r[W-2:0], 1'b0};
        end
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  assign done = done_r;
  assign quot = q_r;
  assign rem  = r_r[W-1:0];

endmodule

>>> hdl/slab_gather_planner.sv
// top level: page list store, in-memory insertion sort and result stream
//
// Pages load at one beat per cycle into a store of MAX_LIST entries. A beat
// with last set starts the plan: a stable insertion sort runs inside the
// store, one read-compare-write step at a time through its single read port.
// Each result then passes through a store read, a bit-serial divide for slab
// and row that is handed over to the output register, where it waits on
// out_ready; the next result is read only once the last one is taken. With a
// pages_per_slab of zero the divide is skipped. The input is not ready while a
// plan is being sorted or sent; it reopens once the last result beat is taken.
module slab_gather_planner #(
  parameter int MAX_LIST  = sgp_pkg::MAX_LIST_DEF,
  parameter int PAGE_BITS = sgp_pkg::PAGE_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [sgp_pkg::CFG_W-1:0]   cfg_data,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [15:0]                 in_page_id,
  input  logic                        in_last,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [5:0]                  out_source_index,
  output logic [15:0]                 out_slab,
  output logic [15:0]                 out_row,
  output logic [5:0]                  out_position,
  output logic [5:0]                  out_group_base,
  output logic                        out_group_start,
  output logic                        out_overflow,
  output logic                        out_last_out
);
  localparam int AW = $clog2(MAX_LIST);
  localparam int CW = $clog2(MAX_LIST + 1);
  localparam int IW = sgp_pkg::IDX_W;
  localparam int W  = sgp_pkg::CFG_W;

  localparam logic [3:0] S_LOAD  = 4'd0;
  localparam logic [3:0] S_OUTER = 4'd1;
  localparam logic [3:0] S_KEYRD = 4'd2;
  localparam logic [3:0] S_KEY   = 4'd3;
  localparam logic [3:0] S_CMPRD = 4'd4;
  localparam logic [3:0] S_CMP   = 4'd5;
  localparam logic [3:0] S_EMRD  = 4'd6;
  localparam logic [3:0] S_EMDIV = 4'd7;
  localparam logic [3:0] S_EMWT  = 4'd8;
  localparam logic [3:0] S_SEND  = 4'd9;

  // page and index memory, one word per entry
  logic [PAGE_BITS-1:0] page_mem [MAX_LIST];
  logic [AW-1:0]        idx_mem  [MAX_LIST];
  logic [PAGE_BITS-1:0] rd_page_r;
  logic [AW-1:0]        rd_idx_r;
  logic                 we;
  logic [AW-1:0]        waddr, raddr;
  logic [PAGE_BITS-1:0] wpage;
  logic [AW-1:0]        widx;

  logic [3:0]           state_r;
  logic [W-1:0]         pps_r;
  logic [CW-1:0]        count_r;
  logic                 ovf_r;
  logic [CW-1:0]        i_r, j_r, k_r;
  logic [PAGE_BITS-1:0] key_r;
  logic [AW-1:0]        keyx_r;
  logic [W-1:0]         prev_slab_r;
  logic [CW-1:0]        base_r;
  logic [AW-1:0]        sidx_r;
  logic                 div_done;
  logic [W-1:0]         div_q, div_r;
  sgp_pkg::div_req_t    dreq;
  logic [W-1:0]         page16;
  logic                 start_grp;

  always_ff @(posedge clk) begin
    if (we) begin
      page_mem[waddr] <= wpage;
      idx_mem[waddr]  <= widx;
    end
    rd_page_r <= page_mem[raddr];
    rd_idx_r  <= idx_mem[raddr];
  end

  assign in_ready  = (state_r == S_LOAD);
  assign cfg_ready = 1'b1;

  // memory port control
  always_comb begin
    we    = 1'b0;
    waddr = count_r[AW-1:0];
    wpage = PAGE_BITS'(in_page_id);
    widx  = count_r[AW-1:0];
    raddr = '0;
    unique case (state_r)
      S_LOAD: we = in_valid && (count_r != CW'(MAX_LIST));
      S_KEYRD: raddr = i_r[AW-1:0];
      S_CMPRD: raddr = AW'(j_r - 1'b1);
      S_CMP: begin
        waddr = j_r[AW-1:0];
        if (j_r != '0 && rd_page_r > key_r) begin
          we = 1'b1; wpage = rd_page_r; widx = rd_idx_r;
        end else begin
          we = 1'b1; wpage = key_r; widx = keyx_r;
        end
      end
      S_EMRD: raddr = k_r[AW-1:0];
      default: ;
    endcase
  end

  assign page16 = W'(rd_page_r);
  assign dreq.start    = (state_r == S_EMDIV) && (pps_r != '0);
  assign dreq.dividend = page16;
  assign dreq.divisor  = pps_r;

  sgp_divider u_div (
    .clk(clk), .rst_n(rst_n), .req(dreq),
    .done(div_done), .quot(div_q), .rem(div_r)
  );

  // sequencer: load, sort, emit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_LOAD;
      pps_r     <= sgp_pkg::PPS_RESET;
      count_r   <= '0;
      ovf_r     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid) pps_r <= cfg_data;
      unique case (state_r)
        S_LOAD: if (in_valid) begin
          if (count_r != CW'(MAX_LIST)) count_r <= count_r + 1'b1;
          else ovf_r <= 1'b1;
          if (in_last) begin
            i_r     <= CW'(1);
            state_r <= S_OUTER;
          end
        end
        S_OUTER: begin
          if (i_r >= count_r) begin
            k_r     <= '0;
            state_r <= S_EMRD;
          end else state_r <= S_KEYRD;
        end
        S_KEYRD: state_r <= S_KEY;
        S_KEY: begin
          key_r   <= rd_page_r;
          keyx_r  <= rd_idx_r;
          j_r     <= i_r;
          state_r <= S_CMPRD;
        end
        S_CMPRD: state_r <= S_CMP;
        S_CMP: begin
          if (j_r != '0 && rd_page_r > key_r) begin
            j_r     <= j_r - 1'b1;
            state_r <= (j_r == CW'(1)) ? S_CMP : S_CMPRD;
          end else begin
            i_r     <= i_r + 1'b1;
            state_r <= S_OUTER;
          end
        end
        S_EMRD: state_r <= S_EMDIV;
        S_EMDIV: begin
          sidx_r  <= rd_idx_r;
          state_r <= (pps_r == '0) ? S_SEND : S_EMWT;
          if (pps_r == '0) begin
            out_slab  <= '1;
            out_row   <= page16;
          end
        end
        S_EMWT: if (div_done) begin
          out_slab <= div_q;
          out_row  <= div_r;
          state_r  <= S_SEND;
        end
        S_SEND: begin
          if (!out_valid) begin
            out_valid        <= 1'b1;
            out_source_index <= IW'(sidx_r);
            out_position     <= IW'(k_r);
            out_group_start  <= start_grp;
            out_group_base   <= start_grp ? IW'(k_r) : IW'(base_r);
            out_overflow     <= ovf_r;
            out_last_out     <= (k_r + 1'b1 == count_r);
            if (start_grp) base_r <= k_r;
            prev_slab_r      <= out_slab;
          end else if (out_ready) begin
            out_valid <= 1'b0;
            if (out_last_out) begin
              count_r <= '0;
              ovf_r   <= 1'b0;
              state_r <= S_LOAD;
            end else begin
              k_r     <= k_r + 1'b1;
              state_r <= S_EMRD;
            end
          end
        end
        default: state_r <= S_LOAD;
      endcase
    end
  end

  assign start_grp = (k_r == '0) || (out_slab != prev_slab_r);

  // checks on the sequencer
  a_no_out_in_load: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_LOAD |-> !out_valid) else $error("result beat while loading");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_LIST)) else $error("fill count beyond store");
  a_ready_load: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> state_r == S_LOAD) else $error("input ready outside loading");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid) else $error("result beat dropped");

endmodule

>>> dv/slab_gather_planner_tb.sv
// testbench for the slab gather planner: random lists, sorted plan checked per beat
module slab_gather_planner_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIST_CAP   = sgp_pkg::MAX_LIST_DEF;
  localparam int STALL_LIMIT = 20000;

  typedef struct packed {
    logic [15:0] page;
    logic        last;
  } page_beat_t;

  typedef struct packed {
    logic [5:0]  source_index;
    logic [15:0] slab;
    logic [15:0] row;
    logic [5:0]  position;
    logic [5:0]  group_base;
    logic        group_start;
    logic        overflow;
    logic        last_out;
  } plan_entry_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [sgp_pkg::CFG_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [15:0] in_page_id = '0;
  logic in_last = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [5:0] out_source_index, out_position, out_group_base;
  logic [15:0] out_slab, out_row;
  logic out_group_start, out_overflow, out_last_out;

  slab_gather_planner DUT (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .in_page_id(in_page_id), .in_last(in_last),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_source_index(out_source_index), .out_slab(out_slab), .out_row(out_row),
    .out_position(out_position), .out_group_base(out_group_base),
    .out_group_start(out_group_start), .out_overflow(out_overflow),
    .out_last_out(out_last_out)
  );

  // clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  page_beat_t  pending_pages[$];
  plan_entry_t plan_expected[$];
  logic [15:0] list_pages[$];
  logic        list_dropped = 1'b0;
  logic [15:0] slab_size = sgp_pkg::PPS_RESET;
  bit          calm = 1'b0;
  int          hold_req = 0;
  int          hold_done = 0;
  int          mismatches = 0;
  int          beats_in = 0;
  int          beats_out = 0;
  int          plans = 0;
  int          overflow_plans = 0;

  // plan prediction: stable sort of the current list, then slab, row and grouping
  task automatic plan_list();
    logic [15:0] pg[LIST_CAP];
    logic [5:0]  ix[LIST_CAP];
    logic [15:0] p, s, r, prev_s;
    logic [5:0]  x, base;
    int n, j;
    plan_entry_t e;
    n = list_pages.size();
    for (int i = 0; i < n; i++) begin
      pg[i] = list_pages[i];
      ix[i] = 6'(i);
    end
    for (int i = 1; i < n; i++) begin
      p = pg[i];
      x = ix[i];
      j = i;
      while (j > 0 && pg[j-1] > p) begin
        pg[j] = pg[j-1];
        ix[j] = ix[j-1];
        j--;
      end
      pg[j] = p;
      ix[j] = x;
    end
    prev_s = '0;
    base = '0;
    for (int k = 0; k < n; k++) begin
      if (slab_size == 0) begin
        s = 16'hFFFF;
        r = pg[k];
      end else begin
        s = pg[k] / slab_size;
        r = pg[k] % slab_size;
      end
      e.group_start = (k == 0) || (s != prev_s);
      if (e.group_start) base = 6'(k);
      prev_s = s;
      e.source_index = ix[k];
      e.slab = s;
      e.row = r;
      e.position = 6'(k);
      e.group_base = base;
      e.overflow = list_dropped;
      e.last_out = (k + 1 == n);
      plan_expected.insert(plan_expected.size(), e);
    end
    plans++;
    if (list_dropped) overflow_plans++;
    list_pages.delete();
    list_dropped = 1'b0;
  endtask

  task automatic take_page(input logic [15:0] page, input logic last);
    if (list_pages.size() < LIST_CAP) list_pages.insert(list_pages.size(), page);
    else list_dropped = 1'b1;
    if (last) plan_list();
  endtask

  // input driver with random idle bursts
  int send_gap = 0;
  always @(posedge clk) begin : drive_pages
    logic busy;
    page_beat_t b;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      busy = in_valid;
      if (in_valid && in_ready) begin
        take_page(in_page_id, in_last);
        beats_in++;
        busy = 1'b0;
      end
      if (!busy) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending_pages.size() > 0) begin
          if (!calm && $urandom_range(0, 5) == 0) begin
            send_gap = $urandom_range(1, 8);
          end else begin
            b = pending_pages.pop_front();
            in_page_id <= b.page;
            in_last <= b.last;
            busy = 1'b1;
          end
        end
      end
      in_valid <= busy;
    end
  end

  // result monitor and receiver back-pressure
  int take_gap = 0;
  int hold_left = 0;
  always @(posedge clk) begin : watch_plan
    plan_entry_t got, want;
    logic rdy;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        got = '{out_source_index, out_slab, out_row, out_position, out_group_base,
                out_group_start, out_overflow, out_last_out};
        beats_out++;
        if (plan_expected.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result beat %p", got);
        end else begin
          want = plan_expected.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) $display("result mismatch: expected %p, got %p", want, got);
          end
        end
      end
      // long hold starts once results are flowing, so the next list backs up
      if (hold_req != hold_done && out_valid) begin
        hold_done = hold_req;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end else if (take_gap > 0) begin
        take_gap--;
        rdy = 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        take_gap = $urandom_range(1, 8);
        rdy = 1'b0;
      end else begin
        rdy = 1'b1;
      end
      out_ready <= rdy;
    end
  end

  // watchdog on cycles without any accepted beat
  int quiet = 0;
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet >= STALL_LIMIT) begin
      $display("watchdog expired, %0d results still owed", plan_expected.size());
      $display("slab_gather_planner test failed");
      $finish;
    end
  end

  task automatic queue_list(input int n, input int spread);
    page_beat_t b;
    for (int i = 0; i < n; i++) begin
      case (spread)
        0: b.page = 16'($urandom);
        1: b.page = 16'($urandom_range(0, 40));
        default: b.page = 16'(16'hFFFF - $urandom_range(0, 40));
      endcase
      b.last = (i == n - 1);
      pending_pages.insert(pending_pages.size(), b);
    end
  endtask

  task automatic queue_page(input logic [15:0] page, input logic last);
    page_beat_t b;
    b.page = page;
    b.last = last;
    pending_pages.insert(pending_pages.size(), b);
  endtask

  // wait until every queued beat is sent and every plan is drained
  task automatic drain();
    @(negedge clk);
    while (pending_pages.size() > 0 || in_valid || plan_expected.size() > 0)
      @(negedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_slab_size(input logic [15:0] v);
    drain();
    cfg_data <= v;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    slab_size = v;
  endtask

  task automatic random_phase(input int items);
    int sent;
    int n;
    sent = 0;
    while (sent < items) begin
      n = $urandom_range(1, 12);
      queue_list(n, $urandom_range(0, 2));
      sent += n;
    end
  endtask

  // stimulus
  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes, ties, repeated slabs at the reset slab size
    queue_page(16'h0000, 1'b1);
    queue_page(16'hFFFF, 1'b1);
    queue_page(16'h0005, 1'b0);
    queue_page(16'h0005, 1'b0);
    queue_page(16'h0003, 1'b0);
    queue_page(16'h0005, 1'b1);
    queue_page(16'hAAAA, 1'b0);
    queue_page(16'h5555, 1'b0);
    queue_page(16'h0100, 1'b0);
    queue_page(16'h00FF, 1'b0);
    queue_page(16'h0101, 1'b1);
    drain();

    // divide by zero and divide by one
    write_slab_size(16'd0);
    queue_page(16'h1234, 1'b0);
    queue_page(16'hFFFF, 1'b1);
    write_slab_size(16'd1);
    queue_page(16'h0007, 1'b0);
    queue_page(16'h0007, 1'b0);
    queue_page(16'h0002, 1'b1);

    // full store, then a list that overflows with last on a dropped page
    write_slab_size(16'd7);
    queue_list(LIST_CAP, 1);
    hold_req++;
    queue_list(LIST_CAP + 3, 0);
    random_phase(10);

    write_slab_size(16'hFFFF);
    random_phase(10);
    write_slab_size(16'h8000);
    random_phase(10);
    write_slab_size(16'($urandom_range(2, 300)));
    queue_list(LIST_CAP + 1, 2);
    random_phase(10);
    write_slab_size(16'h7FFF);
    random_phase(10);

    // last stretch runs without idling
    write_slab_size(16'($urandom_range(1, 65535)));
    calm = 1'b1;
    random_phase(10);
    drain();
    repeat (100) @(posedge clk);

    if (plan_expected.size() > 0) mismatches++;
    $display("%0d page beats in, %0d result beats out over %0d plans (%0d overflowed)",
             beats_in, beats_out, plans, overflow_plans);
    $display("slab sizes covered zero, one, small, mid and full range; %0d mismatches",
             mismatches);
    if (mismatches == 0)
      $display("slab_gather_planner test passed");
    else
      $display("slab_gather_planner test failed");
    $finish;
  end

endmodule
